[src/fpc_pkg.sv]
// ---------------------------------------------------------------------------
// fpc_pkg: shared types and constants for the framed packet checker
// Frame delimiter codes, CRC constants, request and verdict payload types,
// the inter-stage queue entry and the byte-wise CRC-16 update function.
// ---------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

  // Frame delimiters
  localparam logic [7:0] SOH_CODE = 8'h01;
  localparam logic [7:0] STX_CODE = 8'h02;
  localparam logic [7:0] ETX_CODE = 8'h03;
  localparam logic [7:0] EOT_CODE = 8'h04;

  // CRC-16, reflected
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  // Size limits
  localparam int unsigned CNT_W         = 9;
  localparam logic [8:0]  COUNT_MAX     = 9'd511;
  localparam logic [8:0]  SIZE_OVERHEAD = 9'd12;
  localparam logic [8:0]  MIN_SIZE      = 9'd14;
  localparam logic [8:0]  CRC_MIN_SIZE  = 9'd4;

  // Header byte offsets
  localparam logic [8:0] OFS_SOH     = 9'd0;
  localparam logic [8:0] OFS_VERSION = 9'd1;
  localparam logic [8:0] OFS_RX_LO   = 9'd2;
  localparam logic [8:0] OFS_RX_HI   = 9'd3;
  localparam logic [8:0] OFS_TX_LO   = 9'd4;
  localparam logic [8:0] OFS_TX_HI   = 9'd5;
  localparam logic [8:0] OFS_LEN     = 9'd6;
  localparam logic [8:0] OFS_STX     = 9'd7;
  localparam logic [8:0] OFS_CMD     = 9'd8;
  localparam logic [8:0] OFS_STATUS  = 9'd10;
  localparam logic [8:0] OFS_CRC_ON  = 9'd3;

  // Configuration register indexes
  localparam logic REG_VERSION = 1'b0;
  localparam logic [7:0] VERSION_RST = 8'h10;

  // Input request payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  // Verdict payload
  typedef struct packed {
    logic        frame_ok;
    logic        crc_ok;
    logic [15:0] receiver_addr;
    logic [15:0] sender_addr;
    logic [7:0]  command_code;
    logic [7:0]  payload_length;
    logic [7:0]  status_code;
    logic [8:0]  frame_size;
  } out_rsp_t;

  // Classified byte passed from front to back
  typedef struct packed {
    logic [7:0]       data_byte;
    logic             last_byte;
    logic [CNT_W-1:0] idx;
  } q_entry_t;

  // Queue occupancy status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Front-end status
  typedef struct packed {
    logic [CNT_W-1:0] count;
  } front_stat_t;

  // One-byte update of the reflected CRC, LSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    logic        mix;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      mix = c[0] ^ b[k];
      c   = {1'b0, c[15:1]};
      if (mix) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/framed_packet_checker_crc16_top.sv]
// ---------------------------------------------------------------------------
// framed_packet_checker_crc16_top: framed packet checker with CRC-16
// Checks frame layout and the reflected CRC-16 (0x8408, init 0xFFFF) of a
// byte-serial frame and returns one verdict per frame.
// ---------------------------------------------------------------------------
// The block takes one frame byte per cycle while the queue has room, with no
// gaps needed between frames. Each accepted byte passes through a two-entry
// queue into the checking engine, whose combinational unrolled CRC byte
// update sets the one-byte-per-cycle rate. The verdict for a frame is
// registered into the output register when its last byte leaves the queue
// and is held there until taken; while it waits, the input keeps accepting bytes
// until the queue fills. The version register (address 0) may be written
// only while no frame is in flight.
`default_nettype none

module framed_packet_checker_crc16_top (
  input  wire                clk,
  input  wire                rst_n,
  // Byte input
  input  wire                in_valid,
  output logic               in_ready,
  input  fpc_pkg::in_req_t   in_data,
  // Verdict output
  output logic               out_valid,
  input  wire                out_ready,
  output fpc_pkg::out_rsp_t  out_data,
  // Configuration
  input  wire                cfg_psel,
  input  wire                cfg_penable,
  input  wire                cfg_pwrite,
  input  wire  [2:0]         cfg_paddr,
  input  wire  [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import fpc_pkg::*;

  logic        version_sel;
  logic [7:0]  version_byte_r, version_byte_nxt;
  logic        cfg_wr;
  logic        reg_idx;
  logic        q_push, q_pop;
  q_entry_t    q_wdata, q_rdata;
  q_stat_t     q_stat;
  front_stat_t f_stat;

  // Configuration register
  assign cfg_pready  = 1'b1;
  assign reg_idx     = cfg_paddr[2];
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite;
  assign version_sel = (reg_idx == REG_VERSION);

  always_comb begin
    version_byte_nxt = version_byte_r;
    if (cfg_wr && version_sel) begin
      version_byte_nxt = cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_byte_r <= VERSION_RST;
    end else begin
      version_byte_r <= version_byte_nxt;
    end
  end

  assign cfg_prdata = version_sel ? {24'd0, version_byte_r} : 32'd0;

  // Front end
  fpc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .f_stat   (f_stat)
  );

  // Decoupling queue
  fpc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Checking engine
  fpc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .version_byte (version_byte_r),
    .q_stat       (q_stat),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  // Queue never pushed when full nor popped when empty
  a_q_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_stat.full) && !(q_pop && q_stat.empty))
    else $error("queue overflow or underflow");

  // Byte counter restarts after a frame's last byte
  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.last_byte) |=> (f_stat.count == '0))
    else $error("byte counter not cleared after last byte");

  // A new verdict only comes from a queued last byte
  a_verdict_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_pop && q_rdata.last_byte))
    else $error("verdict without a last byte");

endmodule

`default_nettype wire

[src/fpc_front.sv]
// ---------------------------------------------------------------------------
// fpc_front: input acceptance and byte classification
// Accepts one byte per cycle while the queue has room and tags it with its
// position in the frame (saturating byte counter).
// ---------------------------------------------------------------------------
`default_nettype none

module fpc_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  fpc_pkg::in_req_t      in_data,
  input  fpc_pkg::q_stat_t      q_stat,
  output logic                  q_push,
  output fpc_pkg::q_entry_t     q_wdata,
  output fpc_pkg::front_stat_t  f_stat
);
  import fpc_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;

  // Handshake toward the source
  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready;

  // Tag the byte with its frame offset
  always_comb begin
    q_wdata.data_byte = in_data.data_byte;
    q_wdata.last_byte = in_data.last_byte;
    q_wdata.idx       = count_r;
  end

  // Saturating byte counter, cleared after the last byte
  always_comb begin
    count_nxt = count_r;
    if (q_push) begin
      if (in_data.last_byte) begin
        count_nxt = '0;
      end else if (count_r != COUNT_MAX) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign f_stat.count = count_r;

endmodule

`default_nettype wire

[src/fpc_queue.sv]
// ---------------------------------------------------------------------------
// fpc_queue: two-entry queue between front and back
// Lets the front keep taking bytes while the back waits on the output.
// ---------------------------------------------------------------------------
`default_nettype none

module fpc_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  fpc_pkg::q_entry_t   wdata,
  input  wire                 pop,
  output fpc_pkg::q_entry_t   rdata,
  output fpc_pkg::q_stat_t    stat
);
  import fpc_pkg::*;

  q_entry_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  // Occupancy
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign rdata      = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

[src/fpc_back.sv]
// ---------------------------------------------------------------------------
// fpc_back: frame checking engine and verdict register
// Captures header fields, runs the CRC through a three-byte delay line and
// forms the verdict into the output register on the last byte.
// ---------------------------------------------------------------------------
`default_nettype none

module fpc_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire  [7:0]          version_byte,
  input  fpc_pkg::q_stat_t    q_stat,
  input  fpc_pkg::q_entry_t   q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output fpc_pkg::out_rsp_t   out_data
);
  import fpc_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  tail0_r, tail0_nxt;
  logic [7:0]  tail1_r, tail1_nxt;
  logic [7:0]  tail2_r, tail2_nxt;
  logic [7:0]  last_crc_r, last_crc_nxt;
  logic        hdr_good_r, hdr_good_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] rx_r, rx_nxt;
  logic [15:0] tx_r, tx_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  stat_r, stat_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_rsp_t    out_data_r, verdict;
  logic [8:0]  size;
  logic [15:0] checksum;
  logic        slot_free;
  logic        pop_last;

  // Pop unless a verdict is due and the output slot is still occupied
  assign slot_free = !out_valid_r || out_ready;
  assign q_pop     = !q_stat.empty && (!q_rdata.last_byte || slot_free);
  assign pop_last  = q_pop && q_rdata.last_byte;

  // Per-byte state update
  always_comb begin
    hdr_good_nxt = hdr_good_r;
    len_nxt      = len_r;
    rx_nxt       = rx_r;
    tx_nxt       = tx_r;
    cmd_nxt      = cmd_r;
    stat_nxt     = stat_r;
    unique case (q_rdata.idx)
      OFS_SOH:     if (q_rdata.data_byte != SOH_CODE) hdr_good_nxt = 1'b0;
      OFS_VERSION: if (q_rdata.data_byte != version_byte) hdr_good_nxt = 1'b0;
      OFS_RX_LO:   rx_nxt[7:0]  = q_rdata.data_byte;
      OFS_RX_HI:   rx_nxt[15:8] = q_rdata.data_byte;
      OFS_TX_LO:   tx_nxt[7:0]  = q_rdata.data_byte;
      OFS_TX_HI:   tx_nxt[15:8] = q_rdata.data_byte;
      OFS_LEN:     len_nxt      = q_rdata.data_byte;
      OFS_STX:     if (q_rdata.data_byte != STX_CODE) hdr_good_nxt = 1'b0;
      OFS_CMD:     cmd_nxt      = q_rdata.data_byte;
      OFS_STATUS:  stat_nxt     = q_rdata.data_byte;
      default: ;
    endcase

    // The byte three places back enters the CRC
    if (q_rdata.idx >= OFS_CRC_ON) begin
      last_crc_nxt = tail0_r;
      crc_nxt      = crc_feed(crc_r, tail0_r);
    end else begin
      last_crc_nxt = last_crc_r;
      crc_nxt      = crc_r;
    end
    tail0_nxt = tail1_r;
    tail1_nxt = tail2_r;
    tail2_nxt = q_rdata.data_byte;
  end

  // Verdict for the last byte
  always_comb begin
    size     = (q_rdata.idx == COUNT_MAX) ? COUNT_MAX : q_rdata.idx + 1'b1;
    checksum = {tail1_nxt, tail0_nxt};
    verdict.crc_ok   = (size >= CRC_MIN_SIZE) && (checksum == crc_nxt);
    verdict.frame_ok = (size >= MIN_SIZE) && hdr_good_nxt &&
                       ({1'b0, len_nxt} == (size - SIZE_OVERHEAD)) &&
                       (last_crc_nxt == ETX_CODE) &&
                       (q_rdata.data_byte == EOT_CODE);
    verdict.receiver_addr  = rx_nxt;
    verdict.sender_addr    = tx_nxt;
    verdict.command_code   = cmd_nxt;
    verdict.payload_length = len_nxt - 8'd2;
    verdict.status_code    = stat_nxt;
    verdict.frame_size     = size;
  end

  // Frame state registers, cleared after each verdict
  always_ff @(posedge clk) begin
    if (!rst_n || pop_last) begin
      crc_r      <= CRC_INIT;
      tail0_r    <= '0;
      tail1_r    <= '0;
      tail2_r    <= '0;
      last_crc_r <= '0;
      hdr_good_r <= 1'b1;
      len_r      <= '0;
      rx_r       <= '0;
      tx_r       <= '0;
      cmd_r      <= '0;
      stat_r     <= '0;
    end else if (q_pop) begin
      crc_r      <= crc_nxt;
      tail0_r    <= tail0_nxt;
      tail1_r    <= tail1_nxt;
      tail2_r    <= tail2_nxt;
      last_crc_r <= last_crc_nxt;
      hdr_good_r <= hdr_good_nxt;
      len_r      <= len_nxt;
      rx_r       <= rx_nxt;
      tx_r       <= tx_nxt;
      cmd_r      <= cmd_nxt;
      stat_r     <= stat_nxt;
    end
  end

  // Output register
  always_comb begin
    if (pop_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_last) begin
      out_data_r <= verdict;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
